/* rtl/sliding_window_skewness_defines.svh */
// ----------------------------------------------------------------------------
// sliding_window_skewness_defines.svh
// Assertion macros shared by the sliding window skewness block
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SKEWNESS_DEFINES_SVH
`define SLIDING_WINDOW_SKEWNESS_DEFINES_SVH
`ifndef SYNTHESIS
// invariant checked at every clock edge outside reset
`define SWSK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked at every clock edge outside reset
`define SWSK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SWSK_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWSK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/swsk_pkg.sv */
// ----------------------------------------------------------------------------
// swsk_pkg
// Types and constants of the sliding window skewness block
// ----------------------------------------------------------------------------
package swsk_pkg;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned WL_W       = 9;
	localparam int unsigned SKEW_W     = 23;
	localparam int unsigned MARKER_W   = 20;
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned Q_W        = 32;
	localparam int unsigned SK_SHIFT   = 8;
	localparam int unsigned SK_W       = 40;
	localparam int unsigned SQ_IN_W    = 48;
	localparam int unsigned ROOT_W     = 24;
	localparam int unsigned SQ_REM_W   = 26;
	localparam int unsigned MK_W       = 26;
	localparam int unsigned MIN_SEEN   = 3;

	localparam logic [WL_W-1:0]   WL_RESET     = 9'd64;
	localparam logic [WL_W-1:0]   WL_SHORT     = 9'd3;
	localparam logic [SK_W-1:0]   SKEW_POS_MAX = 40'd4194303;
	localparam logic [SK_W-1:0]   SKEW_NEG_MAG = 40'd4194304;
	localparam logic [MK_W-1:0]   MARKER_MAX   = 26'd655360;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_REW_MAX,
		ST_MAX,
		ST_FLAT,
		ST_NORM,
		ST_MOM,
		ST_DIVQ,
		ST_DIVQ_WAIT,
		ST_DIVV,
		ST_DIVV_WAIT,
		ST_SQRT,
		ST_SQRT_WAIT,
		ST_DIVS,
		ST_DIVS_WAIT,
		ST_FIN,
		ST_FIN_FLAT,
		ST_FIN_ZERO
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE,
		OP_SETUP,
		OP_READ_SUM,
		OP_REWIND,
		OP_READ_MAX,
		OP_NORM_INIT,
		OP_NORM_STEP,
		OP_READ_MOM,
		OP_DIVQ_START,
		OP_DIVV_START,
		OP_SQRT_START,
		OP_DIVS_START,
		OP_FIN,
		OP_FIN_FLAT,
		OP_FIN_ZERO
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic seen_lt3;
		logic pass_done;
		logic flat;
		logic norm_ok;
		logic div_busy;
		logic sqrt_busy;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/swsk_sample_if.sv */
// ----------------------------------------------------------------------------
// swsk_sample_if
// Sample channel: valid/ready handshake with one price sample
// ----------------------------------------------------------------------------
interface swsk_sample_if;
	logic                              valid;
	logic                              ready;
	logic [swsk_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* rtl/swsk_result_if.sv */
// ----------------------------------------------------------------------------
// swsk_result_if
// Result channel: valid/ready handshake with skewness and marker size
// ----------------------------------------------------------------------------
interface swsk_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  valid_res;
	logic signed [swsk_pkg::SKEW_W-1:0]    skewness;
	logic [swsk_pkg::MARKER_W-1:0]         marker_size;

	modport source (output valid, output valid_res, output skewness, output marker_size,
		input ready);
	modport sink (input valid, input valid_res, input skewness, input marker_size,
		output ready);
endinterface

/* rtl/swsk_div.sv */
// ----------------------------------------------------------------------------
// swsk_div
// Restoring divider, one quotient bit per cycle, shared by the three divisions
// ----------------------------------------------------------------------------
module swsk_div #(
	parameter int NUMW = 73,
	parameter int DENW = 41
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            busy,
	output logic [NUMW-1:0] quot
);

	localparam int CNTW = $clog2(NUMW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] quo_q;
	logic [DENW-1:0] rem_q;
	logic [DENW-1:0] den_q;
	logic [DENW:0]   sh;
	logic [DENW:0]   diff;
	logic            ge;

	always_comb begin
		sh   = {rem_q, quo_q[NUMW-1]};
		diff = sh - {1'b0, den_q};
		ge   = (sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(NUMW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[DENW-1:0];
				quo_q <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				rem_q <= sh[DENW-1:0];
				quo_q <= {quo_q[NUMW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

/* rtl/swsk_ctrl.sv */
// ----------------------------------------------------------------------------
// swsk_ctrl
// Sequencer: steps the datapath through the passes, divisions and root
// ----------------------------------------------------------------------------
module swsk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  swsk_pkg::dp_status_t  status,
	output swsk_pkg::dp_cmd_t     cmd
);

	swsk_pkg::ctrl_state_t state_q;
	swsk_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swsk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swsk_pkg::ST_IDLE: begin
				if (in_valid) state_d = swsk_pkg::ST_CHECK;
			end
			swsk_pkg::ST_CHECK: begin
				state_d = status.seen_lt3 ? swsk_pkg::ST_FIN_ZERO : swsk_pkg::ST_SUM;
			end
			swsk_pkg::ST_SUM: begin
				if (status.pass_done) state_d = swsk_pkg::ST_REW_MAX;
			end
			swsk_pkg::ST_REW_MAX: state_d = swsk_pkg::ST_MAX;
			swsk_pkg::ST_MAX: begin
				if (status.pass_done) state_d = swsk_pkg::ST_FLAT;
			end
			swsk_pkg::ST_FLAT: begin
				state_d = status.flat ? swsk_pkg::ST_FIN_FLAT : swsk_pkg::ST_NORM;
			end
			swsk_pkg::ST_NORM: begin
				if (status.norm_ok) state_d = swsk_pkg::ST_MOM;
			end
			swsk_pkg::ST_MOM: begin
				if (status.pass_done) state_d = swsk_pkg::ST_DIVQ;
			end
			swsk_pkg::ST_DIVQ: state_d = swsk_pkg::ST_DIVQ_WAIT;
			swsk_pkg::ST_DIVQ_WAIT: begin
				if (!status.div_busy) state_d = swsk_pkg::ST_DIVV;
			end
			swsk_pkg::ST_DIVV: state_d = swsk_pkg::ST_DIVV_WAIT;
			swsk_pkg::ST_DIVV_WAIT: begin
				if (!status.div_busy) state_d = swsk_pkg::ST_SQRT;
			end
			swsk_pkg::ST_SQRT: state_d = swsk_pkg::ST_SQRT_WAIT;
			swsk_pkg::ST_SQRT_WAIT: begin
				if (!status.sqrt_busy) state_d = swsk_pkg::ST_DIVS;
			end
			swsk_pkg::ST_DIVS: state_d = swsk_pkg::ST_DIVS_WAIT;
			swsk_pkg::ST_DIVS_WAIT: begin
				if (!status.div_busy) state_d = swsk_pkg::ST_FIN;
			end
			swsk_pkg::ST_FIN, swsk_pkg::ST_FIN_FLAT, swsk_pkg::ST_FIN_ZERO: begin
				if (status.out_free) state_d = swsk_pkg::ST_IDLE;
			end
			default: state_d = swsk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = swsk_pkg::OP_NONE;
		case (state_q)
			swsk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = swsk_pkg::OP_STORE;
			end
			swsk_pkg::ST_CHECK:   cmd.op = swsk_pkg::OP_SETUP;
			swsk_pkg::ST_SUM:     cmd.op = swsk_pkg::OP_READ_SUM;
			swsk_pkg::ST_REW_MAX: cmd.op = swsk_pkg::OP_REWIND;
			swsk_pkg::ST_MAX:     cmd.op = swsk_pkg::OP_READ_MAX;
			swsk_pkg::ST_FLAT:    cmd.op = swsk_pkg::OP_NORM_INIT;
			swsk_pkg::ST_NORM:    cmd.op = swsk_pkg::OP_NORM_STEP;
			swsk_pkg::ST_MOM:     cmd.op = swsk_pkg::OP_READ_MOM;
			swsk_pkg::ST_DIVQ:    cmd.op = swsk_pkg::OP_DIVQ_START;
			swsk_pkg::ST_DIVV:    cmd.op = swsk_pkg::OP_DIVV_START;
			swsk_pkg::ST_SQRT:    cmd.op = swsk_pkg::OP_SQRT_START;
			swsk_pkg::ST_DIVS:    cmd.op = swsk_pkg::OP_DIVS_START;
			swsk_pkg::ST_FIN: begin
				if (status.out_free) cmd.op = swsk_pkg::OP_FIN;
			end
			swsk_pkg::ST_FIN_FLAT: begin
				if (status.out_free) cmd.op = swsk_pkg::OP_FIN_FLAT;
			end
			swsk_pkg::ST_FIN_ZERO: begin
				if (status.out_free) cmd.op = swsk_pkg::OP_FIN_ZERO;
			end
			default: cmd.op = swsk_pkg::OP_NONE;
		endcase
	end

endmodule

/* rtl/swsk_dp.sv */
// ----------------------------------------------------------------------------
// swsk_dp
// Datapath: sample ring, moment passes, shared divider, square root, output
// ----------------------------------------------------------------------------
`include "sliding_window_skewness_defines.svh"

module swsk_dp #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swsk_pkg::dp_cmd_t                    cmd,
	output swsk_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [swsk_pkg::WL_W-1:0]            cfg_wdata,
	input  logic [swsk_pkg::SAMPLE_W-1:0]        sample,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 out_valid_res,
	output logic signed [swsk_pkg::SKEW_W-1:0]   out_skewness,
	output logic [swsk_pkg::MARKER_W-1:0]        out_marker_size
);

	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int SW   = swsk_pkg::SAMPLE_W + CW;
	localparam int A2W  = 2 * swsk_pkg::MAG_W + CW;
	localparam int A3W  = 3 * swsk_pkg::MAG_W + CW;
	localparam int NUMW = A3W + swsk_pkg::FRAC_W;
	localparam int DENW = A2W;
	localparam int SHW  = $clog2(SW);
	localparam int EW   = (CW > swsk_pkg::WL_W) ? CW : swsk_pkg::WL_W;
	localparam int MW   = swsk_pkg::MAG_W;
	localparam int SQCW = $clog2(swsk_pkg::ROOT_W + 1);

	// sample ring
	logic [swsk_pkg::SAMPLE_W-1:0] ring [WINDOW_MAX];

	logic [swsk_pkg::WL_W-1:0] wl_q;
	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             seen_q;
	logic [CW-1:0]             c_q;
	logic [AW-1:0]             rd_addr_q;
	logic [CW-1:0]             cnt_q;
	logic                      issue;
	logic [AW-1:0]             rewind_addr;
	logic [AW:0]               wp_inc;
	logic [EW-1:0]             n_eff;
	logic [CW-1:0]             c_next;

	// pass pipeline
	logic                          v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic [swsk_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic [SW-1:0]                 cx_s2;
	logic [SW-1:0]                 mag_s3;
	logic                          neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MW-1:0]                 m_s4, m_s5;
	logic [2*MW-1:0]               m2_s5, m2_s6;
	logic [3*MW-1:0]               m3_s6;
	logic [SW-1:0]                 shr, shl;

	logic [SW-1:0]  sum_q;
	logic [SW-1:0]  max_q;
	logic [SW-1:0]  norm_q;
	logic [SHW-1:0] rs_q, ls_q;
	logic [A2W-1:0] a2_q;
	logic [A3W-1:0] a3p_q, a3n_q;
	logic           a3_neg_q;
	logic [swsk_pkg::Q_W-1:0] q_q;

	// shared divider
	logic            div_start;
	logic [NUMW-1:0] div_num;
	logic [DENW-1:0] div_den;
	logic            div_busy;
	logic [NUMW-1:0] div_quot;

	// square root
	logic                          sq_busy_q;
	logic [SQCW-1:0]               sq_cnt_q;
	logic [swsk_pkg::SQ_IN_W-1:0]  sq_rad_q;
	logic [swsk_pkg::SQ_REM_W-1:0] sq_rem_q;
	logic [swsk_pkg::ROOT_W-1:0]   sq_root_q;
	logic [swsk_pkg::SQ_REM_W+1:0] sq_tmp, sq_trial;

	// result
	logic                          out_valid_q;
	logic                          out_free;
	logic                          fin_any;
	logic [swsk_pkg::SK_W-1:0]     sk_raw, sk_sat;
	logic [swsk_pkg::SKEW_W-1:0]   sk_mag;
	logic [swsk_pkg::MK_W-1:0]     mk_raw;
	logic [swsk_pkg::MARKER_W-1:0] mk_sat;

	always_comb begin
		issue = ((cmd.op == swsk_pkg::OP_READ_SUM) || (cmd.op == swsk_pkg::OP_READ_MAX) ||
			(cmd.op == swsk_pkg::OP_READ_MOM)) && (cnt_q != '0);
		rewind_addr = (wp_q == '0) ? AW'(WINDOW_MAX - 1) : wp_q - 1'b1;
		wp_inc      = {1'b0, wp_q} + 1'b1;
		// short settings fall back to the default window, then clamp to the ring
		n_eff = (wl_q < swsk_pkg::WL_SHORT) ? EW'(swsk_pkg::WL_RESET) : EW'(wl_q);
		if (n_eff > EW'(WINDOW_MAX)) n_eff = EW'(WINDOW_MAX);
		c_next = (n_eff < EW'(seen_q)) ? n_eff[CW-1:0] : seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q      <= swsk_pkg::WL_RESET;
			wp_q      <= '0;
			seen_q    <= '0;
			cnt_q     <= '0;
			rd_addr_q <= '0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			v5_s5     <= 1'b0;
			v6_s6     <= 1'b0;
		end else begin
			if (cfg_we) wl_q <= cfg_wdata;
			if (cmd.op == swsk_pkg::OP_STORE) begin
				wp_q <= (wp_inc >= (AW+1)'(WINDOW_MAX)) ? '0 : wp_inc[AW-1:0];
				if (seen_q < CW'(WINDOW_MAX)) seen_q <= seen_q + 1'b1;
			end
			if ((cmd.op == swsk_pkg::OP_SETUP) || (cmd.op == swsk_pkg::OP_REWIND) ||
				(cmd.op == swsk_pkg::OP_NORM_INIT)) begin
				rd_addr_q <= rewind_addr;
				cnt_q     <= (cmd.op == swsk_pkg::OP_SETUP) ? c_next : c_q;
			end else if (issue) begin
				rd_addr_q <= (rd_addr_q == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_q - 1'b1;
				cnt_q     <= cnt_q - 1'b1;
			end
			v1_s1 <= issue;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == swsk_pkg::OP_STORE) ring[wp_q] <= sample;
		if (issue) rd_data_s1 <= ring[rd_addr_q];
	end

	always_comb begin
		shr = mag_s3 >> rs_q;
		shl = shr << ls_q;
	end

	always_ff @(posedge clk) begin
		cx_s2  <= c_q * rd_data_s1;
		neg_s3 <= (cx_s2 < sum_q);
		mag_s3 <= (cx_s2 < sum_q) ? (sum_q - cx_s2) : (cx_s2 - sum_q);
		m_s4   <= shl[MW-1:0];
		neg_s4 <= neg_s3;
		m2_s5  <= (2*MW)'(m_s4) * (2*MW)'(m_s4);
		m_s5   <= m_s4;
		neg_s5 <= neg_s4;
		m3_s6  <= (3*MW)'(m2_s5) * (3*MW)'(m_s5);
		m2_s6  <= m2_s5;
		neg_s6 <= neg_s5;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == swsk_pkg::OP_SETUP) begin
			c_q   <= c_next;
			sum_q <= '0;
			max_q <= '0;
			a2_q  <= '0;
			a3p_q <= '0;
			a3n_q <= '0;
		end
		if ((cmd.op == swsk_pkg::OP_READ_SUM) && v1_s1) begin
			sum_q <= sum_q + SW'(rd_data_s1);
		end
		if ((cmd.op == swsk_pkg::OP_READ_MAX) && v3_s3 && (mag_s3 > max_q)) begin
			max_q <= mag_s3;
		end
		if (cmd.op == swsk_pkg::OP_NORM_INIT) begin
			norm_q <= max_q;
			rs_q   <= '0;
			ls_q   <= '0;
		end else if (cmd.op == swsk_pkg::OP_NORM_STEP) begin
			// one bit a cycle until the largest deviation sits in [2^15, 2^16)
			if (norm_q[SW-1:MW] != '0) begin
				norm_q <= norm_q >> 1;
				rs_q   <= rs_q + 1'b1;
			end else if (!norm_q[MW-1]) begin
				norm_q <= norm_q << 1;
				ls_q   <= ls_q + 1'b1;
			end
		end
		if ((cmd.op == swsk_pkg::OP_READ_MOM) && v6_s6) begin
			a2_q <= a2_q + A2W'(m2_s6);
			if (neg_s6) a3n_q <= a3n_q + A3W'(m3_s6);
			else a3p_q <= a3p_q + A3W'(m3_s6);
		end
		if (cmd.op == swsk_pkg::OP_DIVQ_START) a3_neg_q <= (a3n_q > a3p_q);
		if (cmd.op == swsk_pkg::OP_DIVV_START) q_q <= div_quot[swsk_pkg::Q_W-1:0];
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			swsk_pkg::OP_DIVQ_START: begin
				div_start = 1'b1;
				div_num   = {((a3p_q >= a3n_q) ? (a3p_q - a3n_q) : (a3n_q - a3p_q)),
					{swsk_pkg::FRAC_W{1'b0}}};
				div_den   = a2_q;
			end
			swsk_pkg::OP_DIVV_START: begin
				div_start = 1'b1;
				div_num   = NUMW'({a2_q, {swsk_pkg::FRAC_W{1'b0}}});
				div_den   = DENW'(c_q);
			end
			swsk_pkg::OP_DIVS_START: begin
				div_start = 1'b1;
				div_num   = NUMW'({q_q, {swsk_pkg::SK_SHIFT{1'b0}}});
				div_den   = DENW'(sq_root_q);
			end
			default: div_start = 1'b0;
		endcase
	end

	swsk_div #(
		.NUMW (NUMW),
		.DENW (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// floor square root, two radicand bits per cycle
	always_comb begin
		sq_tmp   = {sq_rem_q, sq_rad_q[swsk_pkg::SQ_IN_W-1 -: 2]};
		sq_trial = {2'b00, sq_root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (cmd.op == swsk_pkg::OP_SQRT_START) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= SQCW'(swsk_pkg::ROOT_W);
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - 1'b1;
			if (sq_cnt_q == SQCW'(1)) sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == swsk_pkg::OP_SQRT_START) begin
			sq_rad_q  <= div_quot[swsk_pkg::SQ_IN_W-1:0];
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_rad_q <= sq_rad_q << 2;
			if (sq_tmp >= sq_trial) begin
				sq_rem_q  <= swsk_pkg::SQ_REM_W'(sq_tmp - sq_trial);
				sq_root_q <= {sq_root_q[swsk_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_tmp[swsk_pkg::SQ_REM_W-1:0];
				sq_root_q <= {sq_root_q[swsk_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	// saturation and marker size
	always_comb begin
		sk_raw = (sq_root_q == '0) ? '0 : div_quot[swsk_pkg::SK_W-1:0];
		if (a3_neg_q) sk_sat = (sk_raw > swsk_pkg::SKEW_NEG_MAG) ? swsk_pkg::SKEW_NEG_MAG : sk_raw;
		else sk_sat = (sk_raw > swsk_pkg::SKEW_POS_MAX) ? swsk_pkg::SKEW_POS_MAX : sk_raw;
		sk_mag = sk_sat[swsk_pkg::SKEW_W-1:0];
		mk_raw = (swsk_pkg::MK_W'(sk_mag) << 3) + (swsk_pkg::MK_W'(sk_mag) << 1);
		mk_sat = (mk_raw > swsk_pkg::MARKER_MAX) ? swsk_pkg::MARKER_MAX[swsk_pkg::MARKER_W-1:0]
			: mk_raw[swsk_pkg::MARKER_W-1:0];
	end

	assign out_free = !out_valid_q || out_ready;
	assign fin_any  = (cmd.op == swsk_pkg::OP_FIN) || (cmd.op == swsk_pkg::OP_FIN_FLAT) ||
		(cmd.op == swsk_pkg::OP_FIN_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			swsk_pkg::OP_FIN: begin
				out_valid_res   <= 1'b1;
				out_skewness    <= a3_neg_q ? -$signed(sk_mag) : $signed(sk_mag);
				out_marker_size <= mk_sat;
			end
			swsk_pkg::OP_FIN_FLAT: begin
				out_valid_res   <= 1'b1;
				out_skewness    <= '0;
				out_marker_size <= '0;
			end
			swsk_pkg::OP_FIN_ZERO: begin
				out_valid_res   <= 1'b0;
				out_skewness    <= '0;
				out_marker_size <= '0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	assign status.seen_lt3  = (seen_q < CW'(swsk_pkg::MIN_SEEN));
	assign status.pass_done = (cnt_q == '0) &&
		!(v1_s1 || v2_s2 || v3_s3 || v4_s4 || v5_s5 || v6_s6);
	assign status.flat      = (max_q == '0);
	assign status.norm_ok   = (norm_q[SW-1:MW] == '0) && norm_q[MW-1];
	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sq_busy_q;
	assign status.out_free  = out_free;

	`SWSK_ASSERT(a_wp_range, clk, arst_n, 32'(wp_q) < WINDOW_MAX, "write pointer past ring end")
	`SWSK_ASSERT(a_seen_sat, clk, arst_n, seen_q <= CW'(WINDOW_MAX), "sample count past window max")
	`SWSK_ASSERT_IMPL(a_norm_range, clk, arst_n, cmd.op == swsk_pkg::OP_READ_MOM, norm_q[SW-1:MW] == '0 && norm_q[MW-1], "moment pass with unnormalized scale")
	`SWSK_ASSERT_IMPL(a_window_ok, clk, arst_n, issue, c_q >= CW'(swsk_pkg::MIN_SEEN) && c_q <= seen_q, "window count outside seen samples")
	`SWSK_ASSERT_IMPL(a_fin_free, clk, arst_n, fin_any, !out_valid_q || out_ready, "result overwrites pending transfer")

endmodule

/* rtl/sliding_window_skewness.sv */
// ----------------------------------------------------------------------------
// sliding_window_skewness
// Moving-window population skewness of a price stream, top level
// ----------------------------------------------------------------------------
// usage:
//   samples: one price sample per transfer (valid/ready); results: one result
//   per sample with valid_res, skewness (signed Q6.16) and marker_size (Q4.16).
//   cfg_we/cfg_wdata write the window length; write only while the block idles.
// timing for a window of c samples, one item at a time: from the sample
//   transfer to the earliest result transfer, the three passes over the ring
//   memory (one read per cycle) and the bit-serial divider dominate. With
//   fewer than three samples seen the passes and divisions are skipped.
// throughput: the next sample is taken once the previous result is in the
//   output register, even if that result still waits to be taken.
// reset: ring contents are not cleared; write pointer and sample count go to
//   zero, window length to 64.
// stall: a held result blocks only the load of the next one; the block waits
//   at its final step until the output register frees up.
// ----------------------------------------------------------------------------
module sliding_window_skewness #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swsk_sample_if.sink                   samples,
	swsk_result_if.source                 results,
	input  logic                          cfg_we,
	input  logic [swsk_pkg::WL_W-1:0]     cfg_wdata
);

	swsk_pkg::dp_cmd_t    cmd;
	swsk_pkg::dp_status_t status;

	swsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	swsk_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.sample          (samples.sample),
		.out_ready       (results.ready),
		.out_valid       (results.valid),
		.out_valid_res   (results.valid_res),
		.out_skewness    (results.skewness),
		.out_marker_size (results.marker_size)
	);

endmodule

/* test/sliding_window_skewness_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_skewness_tb
// Drives price samples through the skewness block under several window
// lengths, predicts each result with a local integer model of the moment
// arithmetic or takes it from a directed row, and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module sliding_window_skewness_tb;

	localparam int RING_DEPTH  = 256;
	localparam int IDLE_LIMIT  = 40000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                               valid_res;
		logic signed [swsk_pkg::SKEW_W-1:0] skewness;
		logic [swsk_pkg::MARKER_W-1:0]      marker_size;
	} skew_result_t;

	typedef struct {
		logic [swsk_pkg::SAMPLE_W-1:0] sample;
		bit                            typed;
		skew_result_t                  result;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [swsk_pkg::WL_W-1:0]   cfg_wdata = '0;

	swsk_sample_if smp ();
	swsk_result_if rsl ();

	sliding_window_skewness dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.results   (rsl),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// local copy of the block state
	logic [swsk_pkg::SAMPLE_W-1:0] price_ring [RING_DEPTH];
	int unsigned                   wr_ptr;
	int unsigned                   seen_count;
	logic [swsk_pkg::WL_W-1:0]     window_len;

	skew_result_t expected_results [$];
	int unsigned  mismatches;
	int unsigned  idle_cycles;
	int unsigned  stall_mode;
	int unsigned  stall_tick;

	function automatic longint unsigned floor_sqrt(input longint unsigned val);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > val)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (val >= root + bitv) begin
				val  = val - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic skew_result_t window_skewness(
		input logic [swsk_pkg::SAMPLE_W-1:0] x);
		skew_result_t    r;
		int unsigned     n, c, pos, rs, ls;
		longint unsigned sum, maxm, a2, a3p, a3n, a3, q, v, sk, mk, m, m2, cx;
		longint unsigned mag [RING_DEPTH];
		bit              neg [RING_DEPTH];
		bit              skneg;
		sum = 0; maxm = 0; a2 = 0; a3p = 0; a3n = 0;
		r = '0;
		price_ring[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
		if (seen_count < RING_DEPTH)
			seen_count++;
		if (seen_count < swsk_pkg::MIN_SEEN)
			return r;
		r.valid_res = 1'b1;
		n = (window_len < swsk_pkg::WL_SHORT) ? int'(swsk_pkg::WL_RESET) : int'(window_len);
		if (n > RING_DEPTH)
			n = RING_DEPTH;
		c = (n < seen_count) ? n : seen_count;
		pos = wr_ptr;
		for (int i = 0; i < c; i++) begin
			pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
			sum += price_ring[pos];
		end
		pos = wr_ptr;
		for (int i = 0; i < c; i++) begin
			pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
			cx = longint'(c) * price_ring[pos];
			neg[i] = (cx < sum);
			mag[i] = neg[i] ? sum - cx : cx - sum;
			if (mag[i] > maxm)
				maxm = mag[i];
		end
		if (maxm == 0)
			return r;
		rs = 0; ls = 0;
		while ((maxm >> rs) >= 65536) rs++;
		while ((maxm << ls) < 32768) ls++;
		for (int i = 0; i < c; i++) begin
			m  = (mag[i] >> rs) << ls;
			m2 = m * m;
			a2 += m2;
			if (neg[i]) a3n += m2 * m;
			else        a3p += m2 * m;
		end
		skneg = (a3p < a3n);
		a3 = skneg ? a3n - a3p : a3p - a3n;
		q = (a3 / a2) << 16;
		q += ((a3 % a2) << 16) / a2;
		v = floor_sqrt((a2 << 16) / c);
		sk = (v == 0) ? 0 : (q << 8) / v;
		if (skneg && sk > swsk_pkg::SKEW_NEG_MAG)
			sk = swsk_pkg::SKEW_NEG_MAG;
		if (!skneg && sk > swsk_pkg::SKEW_POS_MAX)
			sk = swsk_pkg::SKEW_POS_MAX;
		mk = sk * 10;
		if (mk > swsk_pkg::MARKER_MAX)
			mk = swsk_pkg::MARKER_MAX;
		r.skewness    = skneg ? swsk_pkg::SKEW_W'(-sk) : swsk_pkg::SKEW_W'(sk);
		r.marker_size = swsk_pkg::MARKER_W'(mk);
		return r;
	endfunction

	task automatic write_window(input logic [swsk_pkg::WL_W-1:0] wl);
		cfg_we    <= 1'b1;
		cfg_wdata <= wl;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_len = wl;
	endtask

	// one transfer; valid stays high when more_follows so bursts run back to back
	task automatic send_sample(input logic [swsk_pkg::SAMPLE_W-1:0] x, input bit typed,
		input skew_result_t typed_res, input bit more_follows);
		skew_result_t p;
		smp.valid  <= 1'b1;
		smp.sample <= x;
		do @(posedge clk); while (!smp.ready);
		p = window_skewness(x);
		expected_results.push_back(typed ? typed_res : p);
		if (!more_follows)
			smp.valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		skew_result_t want;
		if (arst_n) begin
			if ((smp.valid && smp.ready) || (rsl.valid && rsl.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sliding_window_skewness_tb failed");
				$finish;
			end
			if (rsl.valid && rsl.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result transfer at %0t", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (rsl.valid_res !== want.valid_res || rsl.skewness !== want.skewness ||
						rsl.marker_size !== want.marker_size) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch at %0t: exp v=%0b sk=%0d mk=%0d got v=%0b sk=%0d mk=%0d",
								$realtime, want.valid_res, want.skewness, want.marker_size,
								rsl.valid_res, rsl.skewness, rsl.marker_size);
					end
				end
			end
		end
	end

	// receiver stalls on a pattern that is redrawn at random from time to time
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 300 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: begin
				rsl.ready <= 1'b1;
			end
			1: begin
				rsl.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsl.ready <= (stall_tick % 4 == 0);
			end
		endcase
	end

	function automatic logic [swsk_pkg::SAMPLE_W-1:0] next_price(
		input logic [swsk_pkg::SAMPLE_W-1:0] base,
		input logic [swsk_pkg::SAMPLE_W-1:0] last);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom();
			3, 4, 5: return base + $urandom_range(0, 200);
			6:       return last;
			7:       return base + ($urandom() >> $urandom_range(0, 31));
			8:       return $urandom_range(0, 15);
			default: return ~($urandom_range(0, 15));
		endcase
	endfunction

	stim_row_t directed [$];

	function automatic stim_row_t row(input logic [swsk_pkg::SAMPLE_W-1:0] x,
		input bit typed, input logic v, input logic signed [swsk_pkg::SKEW_W-1:0] sk,
		input logic [swsk_pkg::MARKER_W-1:0] mk);
		stim_row_t s;
		s.sample = x;
		s.typed  = typed;
		s.result = '{v, sk, mk};
		return s;
	endfunction

	initial begin
		logic [swsk_pkg::WL_W-1:0]     windows [] = '{9'd5, 9'd0, 9'd1, 9'd2, 9'd4, 9'd16,
			9'd256, 9'd3, 9'd511, 9'd300, 9'd7, 9'd64};
		int unsigned                   counts [] = '{90, 40, 30, 30, 90, 90, 50, 90, 40, 40,
			90, 60};
		logic [swsk_pkg::SAMPLE_W-1:0] base, last;
		bit                            more;

		smp.valid  = 1'b0;
		smp.sample = '0;
		rsl.ready  = 1'b0;
		stall_mode = 0;
		stall_tick = 0;
		idle_cycles = 0;
		mismatches = 0;
		wr_ptr = 0;
		seen_count = 0;
		window_len = swsk_pkg::WL_RESET;
		foreach (price_ring[i]) price_ring[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default window of 64 for the first rows, then the shortest legal one
		directed.push_back(row(32'h0000_0000, 1, 1'b0, 0, 0));
		directed.push_back(row(32'hFFFF_FFFF, 1, 1'b0, 0, 0));
		directed.push_back(row(32'h0000_0000, 0, 0, 0, 0));
		directed.push_back(row(32'hFFFF_FFFF, 0, 0, 0, 0));
		directed.push_back(row(32'h0000_0001, 0, 0, 0, 0));
		foreach (directed[i])
			send_sample(directed[i].sample, directed[i].typed, directed[i].result,
				i + 1 < directed.size());
		drain_results();
		write_window(swsk_pkg::WL_SHORT);
		directed.delete();
		directed.push_back(row(32'hFFFF_FFFF, 0, 0, 0, 0));
		directed.push_back(row(32'hFFFF_FFFF, 0, 0, 0, 0));
		// flat window: all three equal
		directed.push_back(row(32'hFFFF_FFFF, 1, 1'b1, 0, 0));
		directed.push_back(row(32'h0000_0000, 0, 0, 0, 0));
		directed.push_back(row(32'h0000_0000, 0, 0, 0, 0));
		directed.push_back(row(32'h0000_0000, 1, 1'b1, 0, 0));
		directed.push_back(row(32'd100, 0, 0, 0, 0));
		directed.push_back(row(32'd1, 0, 0, 0, 0));
		directed.push_back(row(32'd2, 0, 0, 0, 0));
		directed.push_back(row(32'd3, 0, 0, 0, 0));
		directed.push_back(row(32'hAAAA_AAAA, 0, 0, 0, 0));
		directed.push_back(row(32'h5555_5555, 0, 0, 0, 0));
		directed.push_back(row(32'h8000_0000, 0, 0, 0, 0));
		foreach (directed[i])
			send_sample(directed[i].sample, directed[i].typed, directed[i].result,
				i + 1 < directed.size());
		last = '0;

		foreach (windows[w]) begin
			drain_results();
			write_window(windows[w]);
			base = $urandom();
			for (int k = 0; k < counts[w]; ) begin
				int unsigned burst;
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst && k < counts[w]; b++, k++) begin
					last = next_price(base, last);
					more = (b + 1 < burst) && (k + 1 < counts[w]);
					send_sample(last, 0, '0, more);
				end
				// valid drops between bursts
				repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 600 : 6))
					@(posedge clk);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("sliding_window_skewness_tb passed");
		else
			$display("sliding_window_skewness_tb failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/swsk_pkg.sv
rtl/swsk_sample_if.sv
rtl/swsk_result_if.sv
rtl/swsk_div.sv
rtl/swsk_ctrl.sv
rtl/swsk_dp.sv
rtl/sliding_window_skewness.sv
test/sliding_window_skewness_tb.sv
